### src/mldr_pkg.sv
`default_nettype none
package mldr_pkg;

    localparam int FRAC_BITS   = 4;
    localparam int SCREEN      = 1024;
    localparam int COORD_W     = 14;
    localparam int CUR_W       = 11;
    localparam int ZW          = 16;
    localparam int NUM_W       = 34;
    localparam int DEN_W       = 30;
    localparam int SUM_W       = ZW + DEN_W + 1;
    localparam int DIV_STEPS   = ZW;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // One pixel job handed from the stepping front to the depth back end.
    typedef struct packed {
        logic                    no_pixel;
        logic                    last_pixel;
        logic                    in_bounds;
        logic [CUR_W-2:0]        px;
        logic [CUR_W-1:0]        py;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic [ZW-1:0]           za;
        logic [ZW-1:0]           zb;
    } t_entry;

    typedef enum logic [1:0] {F_IDLE, F_PROD, F_PUSH} t_fstate;
    typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUM, B_DIV, B_OUT} t_bstate;

endpackage
`default_nettype wire

### src/mldr_fifo.sv
`default_nettype none
module mldr_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire mldr_pkg::t_entry i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output mldr_pkg::t_entry      o_data
);
    mldr_pkg::t_entry r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd];

    // Two-entry queue; pointers toggle on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

### src/mldr_front.sv
`default_nettype none
module mldr_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_kind,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_end_y,
    input  wire logic [mldr_pkg::ZW-1:0]      i_start_inv_depth,
    input  wire logic [mldr_pkg::ZW-1:0]      i_end_inv_depth,
    output logic                              o_push,
    output mldr_pkg::t_entry                  o_entry,
    input  wire logic                         i_full
);
    localparam int CW = mldr_pkg::COORD_W;
    localparam int UW = mldr_pkg::CUR_W;
    localparam int F  = mldr_pkg::FRAC_BITS;

    mldr_pkg::t_fstate r_state, n_state;
    logic [UW-1:0]   r_cur_x, r_cur_y;
    logic [31:0]     r_dec;
    logic [CW-1:0]   r_sx, r_sy, r_ex, r_ey;
    logic [mldr_pkg::ZW-1:0] r_za, r_zb;
    logic [UW-2:0]   r_px;
    logic [UW-1:0]   r_py;
    logic [UW-1:0]   r_pxf;
    logic            r_nopix, r_last, r_inb;
    logic signed [33:0] r_p1, r_p2;
    logic [27:0]     r_q1, r_q2;

    logic signed [CW:0] a, b, la, lb, vx, vy;
    logic signed [5:0]  xo;
    logic signed [6:0]  yo;
    logic signed [CW+1:0] ab;
    logic signed [18:0] rx, ry;
    logic               done, dec_pos, step;
    logic [UW-1:0]      ny, nx;
    logic [31:0]        ndec;
    logic [31:0]        ldec;
    logic signed [22:0] lsum;

    assign a  = $signed({1'b0, r_ey}) - $signed({1'b0, r_sy});
    assign b  = $signed({1'b0, r_sx}) - $signed({1'b0, r_ex});
    assign ab = $signed({a[CW], a}) + $signed({b[CW], b});
    assign vx = -b;
    assign vy = a;
    assign done    = ({r_cur_x, {F{1'b0}}} >= {{(UW+F-CW){1'b0}}, r_ex});
    assign dec_pos = (r_dec != 32'd0) && !r_dec[31];
    assign step    = i_valid && o_ready && (i_kind == mldr_pkg::KIND_STEP);

    // Load: initial decision from the subpixel offsets of the first endpoint.
    assign la   = $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
    assign lb   = $signed({1'b0, i_start_x}) - $signed({1'b0, i_end_x});
    assign xo   = 6'sd16 - $signed({1'b0, i_start_x[F-1:0], 1'b0});
    assign yo   = 7'sd32 - $signed({2'b0, i_start_y[F-1:0], 1'b0});
    assign lsum = 23'(la * xo) + 23'(lb * yo);
    assign ldec = 32'(lsum);

    // Advance: midpoint step; the increments are signed and sign-extended.
    always_comb begin
        if (dec_pos) begin
            ndec = r_dec + 32'($signed({ab, 5'b0}));
            ny   = r_cur_y + 1'b1;
        end else begin
            ndec = r_dec + 32'($signed({a, 5'b0}));
            ny   = r_cur_y;
        end
        nx = r_cur_x + 1'b1;
    end

    // Pixel centre relative to the start, in half-subpixel units.
    assign rx = $signed({3'b0, r_pxf, 5'b0}) + 19'sd16 - $signed({4'b0, r_sx, 1'b0});
    assign ry = $signed({3'b0, r_py, 5'b0}) + 19'sd16 - $signed({4'b0, r_sy, 1'b0});

    always_comb begin
        n_state = r_state;
        o_ready = (r_state == mldr_pkg::F_IDLE);
        o_push  = 1'b0;
        unique case (r_state)
            mldr_pkg::F_IDLE: begin
                if (step) begin
                    n_state = done ? mldr_pkg::F_PUSH : mldr_pkg::F_PROD;
                end
            end
            mldr_pkg::F_PROD: n_state = mldr_pkg::F_PUSH;
            mldr_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = mldr_pkg::F_IDLE;
                end
            end
            default: n_state = mldr_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_entry            = '0;
        o_entry.no_pixel   = r_nopix;
        if (!r_nopix) begin
            o_entry.last_pixel = r_last;
            o_entry.in_bounds  = r_inb;
            o_entry.px         = r_px;
            o_entry.py         = r_py;
            o_entry.num        = r_p1 + r_p2;
            o_entry.den        = {({1'b0, r_q1} + {1'b0, r_q2}), 1'b0};
            o_entry.za         = r_za;
            o_entry.zb         = r_zb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mldr_pkg::F_IDLE;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_dec   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_ex    <= '0;
            r_ey    <= '0;
            r_za    <= '0;
            r_zb    <= '0;
        end else begin
            r_state <= n_state;
            if (i_valid && o_ready && i_kind == mldr_pkg::KIND_LOAD) begin
                r_sx    <= i_start_x;
                r_sy    <= i_start_y;
                r_ex    <= i_end_x;
                r_ey    <= i_end_y;
                r_za    <= i_start_inv_depth;
                r_zb    <= i_end_inv_depth;
                r_cur_x <= {{(UW-(CW-F)){1'b0}}, i_start_x[CW-1:F]};
                r_cur_y <= {{(UW-(CW-F)){1'b0}}, i_start_y[CW-1:F]};
                r_dec   <= ldec;
            end else if (step && !done) begin
                r_dec   <= ndec;
                r_cur_y <= ny;
                r_cur_x <= nx;
            end
        end
    end

    // Pixel job fields and the dot-product terms.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_nopix <= done;
            r_px    <= r_cur_x[UW-2:0];
            r_pxf   <= r_cur_x;
            r_py    <= ny;
            r_inb   <= !r_cur_x[UW-1] && !ny[UW-1];
            r_last  <= ({nx, {F{1'b0}}} >= {{(UW+F-CW){1'b0}}, r_ex});
        end
        if (r_state == mldr_pkg::F_PROD) begin
            r_p1 <= 34'(rx * vx);
            r_p2 <= 34'(ry * vy);
            r_q1 <= 28'(vx * vx);
            r_q2 <= 28'(vy * vy);
        end
    end
endmodule
`default_nettype wire

### src/mldr_back.sv
`default_nettype none
module mldr_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  wire mldr_pkg::t_entry            i_entry,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [mldr_pkg::CUR_W-2:0]       o_pixel_x,
    output logic [mldr_pkg::CUR_W-1:0]       o_pixel_y,
    output logic [mldr_pkg::ZW-1:0]          o_depth,
    output logic                             o_in_bounds,
    output logic                             o_last_pixel,
    output logic                             o_no_pixel
);
    localparam int DW = mldr_pkg::DEN_W;
    localparam int ZW = mldr_pkg::ZW;
    localparam int SW = mldr_pkg::SUM_W;

    mldr_pkg::t_bstate r_state, n_state;
    logic [DW-1:0]  r_n, r_d;
    logic [ZW-1:0]  r_za, r_zb;
    logic [SW-1:0]  r_m1, r_m2;
    logic [DW:0]    r_rem;
    logic [ZW-1:0]  r_low;
    logic [ZW-1:0]  r_q;
    logic [mldr_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [DW-1:0]  clamp_n;
    logic           direct;
    logic [SW-1:0]  sum;
    logic [DW+1:0]  trial;
    logic           fits;

    // Clamp the projection parameter to 0..1.
    always_comb begin
        if (i_entry.num < 0) begin
            clamp_n = '0;
        end else if (i_entry.num > $signed({{(mldr_pkg::NUM_W-DW){1'b0}}, i_entry.den})) begin
            clamp_n = i_entry.den;
        end else begin
            clamp_n = i_entry.num[DW-1:0];
        end
    end

    assign direct = i_entry.no_pixel || (i_entry.den == '0);
    assign sum    = r_m1 + r_m2 + {{(SW-DW+1){1'b0}}, r_d[DW-1:1]};
    assign trial  = {r_rem, r_low[ZW-1]};
    assign fits   = (trial >= {2'b0, r_d});

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_valid = (r_state == mldr_pkg::B_OUT);
        unique case (r_state)
            mldr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = direct ? mldr_pkg::B_OUT : mldr_pkg::B_MUL;
                end
            end
            mldr_pkg::B_MUL: n_state = mldr_pkg::B_SUM;
            mldr_pkg::B_SUM: n_state = mldr_pkg::B_DIV;
            mldr_pkg::B_DIV: begin
                if (r_cnt == mldr_pkg::DIV_CNT_W'(mldr_pkg::DIV_STEPS - 1)) begin
                    n_state = mldr_pkg::B_OUT;
                end
            end
            mldr_pkg::B_OUT: begin
                if (i_ready) begin
                    n_state = mldr_pkg::B_IDLE;
                end
            end
            default: n_state = mldr_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mldr_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: blend products, then a restoring divide, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_n          <= clamp_n;
            r_d          <= i_entry.den;
            r_za         <= i_entry.za;
            r_zb         <= i_entry.zb;
            o_pixel_x    <= i_entry.px;
            o_pixel_y    <= i_entry.py;
            o_in_bounds  <= i_entry.in_bounds;
            o_last_pixel <= i_entry.last_pixel;
            o_no_pixel   <= i_entry.no_pixel;
            o_depth      <= i_entry.za;
        end
        if (r_state == mldr_pkg::B_MUL) begin
            r_m1 <= SW'(r_za * (r_d - r_n));
            r_m2 <= SW'(r_zb * r_n);
        end
        if (r_state == mldr_pkg::B_SUM) begin
            r_rem <= sum[SW-1:ZW];
            r_low <= sum[ZW-1:0];
            r_cnt <= '0;
        end
        if (r_state == mldr_pkg::B_DIV) begin
            r_rem <= fits ? (DW+1)'(trial - {2'b0, r_d}) : trial[DW:0];
            r_low <= {r_low[ZW-2:0], 1'b0};
            r_q   <= {r_q[ZW-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
            if (n_state == mldr_pkg::B_OUT) begin
                o_depth <= {r_q[ZW-2:0], fits};
            end
        end
    end
endmodule
`default_nettype wire

### src/midpoint_line_depth_rasterizer.sv
`default_nettype none
// Channel | Handshake          | Payload
// input   | i_valid / o_ready  | i_kind, i_start_x/y, i_end_x/y, i_start/end_inv_depth
// output  | o_valid / i_ready  | o_pixel_x/y, o_depth, o_in_bounds, o_last_pixel, o_no_pixel
//
// A load is taken in the front end's idle state; an advance passes through the product
// and push states, or straight to push when the segment is already finished.
// Each pixel then passes the back end's multiply, sum and 16-step restoring divide
// states; a finished-segment or zero-length result goes straight to the output.
// Synchronous active-low reset clears the segment, so advances give no-pixel.
// A two-entry queue lets the front keep stepping while a result waits on i_ready.
module midpoint_line_depth_rasterizer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_kind,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_end_y,
    input  wire logic [mldr_pkg::ZW-1:0]      i_start_inv_depth,
    input  wire logic [mldr_pkg::ZW-1:0]      i_end_inv_depth,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [mldr_pkg::CUR_W-2:0]        o_pixel_x,
    output logic [mldr_pkg::CUR_W-1:0]        o_pixel_y,
    output logic [mldr_pkg::ZW-1:0]           o_depth,
    output logic                              o_in_bounds,
    output logic                              o_last_pixel,
    output logic                              o_no_pixel
);
    mldr_pkg::t_entry push_data, pop_data;
    logic push, pop, full, empty;

    mldr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_start_inv_depth(i_start_inv_depth), .i_end_inv_depth(i_end_inv_depth),
        .o_push(push), .o_entry(push_data), .i_full(full)
    );

    mldr_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(push_data),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(pop_data)
    );

    mldr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_entry(pop_data),
        .o_pop(pop), .o_valid(o_valid), .i_ready(i_ready),
        .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y), .o_depth(o_depth),
        .o_in_bounds(o_in_bounds), .o_last_pixel(o_last_pixel), .o_no_pixel(o_no_pixel)
    );

    // A no-pixel result carries all-zero fields.
    a_nopix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_pixel |-> o_depth == '0 && !o_in_bounds && !o_last_pixel
            && o_pixel_x == '0 && o_pixel_y == '0)
        else $error("no-pixel result with nonzero fields");

    // An in-screen flag implies the row is on screen.
    a_inb_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_bounds |-> o_pixel_y < mldr_pkg::CUR_W'(mldr_pkg::SCREEN))
        else $error("in-bounds pixel off screen");

    // The result stays stable while it waits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_depth) && $stable(o_pixel_x))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

### tb/mldr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mldr_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         o_ready,
    input  wire logic                         i_kind,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [mldr_pkg::COORD_W-1:0] i_end_y,
    input  wire logic [mldr_pkg::ZW-1:0]      i_start_inv_depth,
    input  wire logic [mldr_pkg::ZW-1:0]      i_end_inv_depth,
    input  wire logic                         o_valid,
    input  wire logic                         i_ready,
    input  wire logic [mldr_pkg::CUR_W-2:0]   o_pixel_x,
    input  wire logic [mldr_pkg::CUR_W-1:0]   o_pixel_y,
    input  wire logic [mldr_pkg::ZW-1:0]      o_depth,
    input  wire logic                         o_in_bounds,
    input  wire logic                         o_last_pixel,
    input  wire logic                         o_no_pixel,
    output int                                o_errors,
    output int                                o_pending
);
    typedef struct {
        logic [mldr_pkg::CUR_W-2:0] px;
        logic [mldr_pkg::CUR_W-1:0] py;
        logic [mldr_pkg::ZW-1:0]    depth;
        logic                       in_bounds;
        logic                       last_pixel;
        logic                       no_pixel;
    } t_pixel;

    t_pixel pixel_q[$];

    // Mirror of the segment walker state.
    logic [mldr_pkg::CUR_W-1:0]   walk_x, walk_y;
    logic [31:0]                  walk_dec;
    logic [mldr_pkg::COORD_W-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic [mldr_pkg::ZW-1:0]      seg_za, seg_zb;

    assign o_pending = pixel_q.size();

    function automatic logic [mldr_pkg::ZW-1:0] blend_depth(
            input logic [mldr_pkg::CUR_W-1:0] px,
            input logic [mldr_pkg::CUR_W-1:0] py);
        longint vx, vy, rx, ry, num, den2;
        longint unsigned sum;
        vx = longint'(seg_ex) - longint'(seg_sx);
        vy = longint'(seg_ey) - longint'(seg_sy);
        rx = longint'(px) * 32 + 16 - 2 * longint'(seg_sx);
        ry = longint'(py) * 32 + 16 - 2 * longint'(seg_sy);
        num = rx * vx + ry * vy;
        den2 = 2 * (vx * vx + vy * vy);
        if (den2 == 0) return seg_za;
        if (num < 0) num = 0;
        if (num > den2) num = den2;
        sum = longint'(seg_za) * (den2 - num) + longint'(seg_zb) * num + den2 / 2;
        return mldr_pkg::ZW'(sum / den2);
    endfunction

    // Apply one accepted input transfer; an advance queues the pixel it should give.
    task automatic walk_segment(input logic kind);
        longint a, b, xo, yo;
        t_pixel p;
        a = longint'(seg_ey) - longint'(seg_sy);
        b = longint'(seg_sx) - longint'(seg_ex);
        if (kind == mldr_pkg::KIND_LOAD) begin
            seg_sx = i_start_x; seg_sy = i_start_y;
            seg_ex = i_end_x;   seg_ey = i_end_y;
            seg_za = i_start_inv_depth; seg_zb = i_end_inv_depth;
            a = longint'(seg_ey) - longint'(seg_sy);
            b = longint'(seg_sx) - longint'(seg_ex);
            xo = 16 - 2 * longint'(seg_sx[3:0]);
            yo = 32 - 2 * longint'(seg_sy[3:0]);
            walk_x = mldr_pkg::CUR_W'(seg_sx >> mldr_pkg::FRAC_BITS);
            walk_y = mldr_pkg::CUR_W'(seg_sy >> mldr_pkg::FRAC_BITS);
            walk_dec = 32'(a * xo + b * yo);
            return;
        end
        p = '{default: '0};
        if ({walk_x, 4'b0} >= {4'b0, seg_ex}) begin
            p.no_pixel = 1'b1;
        end else begin
            if (walk_dec != 0 && !walk_dec[31]) begin
                walk_dec = walk_dec + 32'((a + b) * 32);
                walk_y = walk_y + 1'b1;
            end else begin
                walk_dec = walk_dec + 32'(a * 32);
            end
            p.px = walk_x[mldr_pkg::CUR_W-2:0];
            p.py = walk_y;
            p.depth = blend_depth(walk_x, walk_y);
            p.in_bounds = (walk_x < mldr_pkg::SCREEN) && (walk_y < mldr_pkg::SCREEN);
            walk_x = walk_x + 1'b1;
            p.last_pixel = {walk_x, 4'b0} >= {4'b0, seg_ex};
        end
        pixel_q.push_back(p);
    endtask

    always @(posedge i_clk) begin
        t_pixel e;
        if (!i_rst_n) begin
            walk_x <= '0; walk_y <= '0; walk_dec <= '0;
            seg_sx <= '0; seg_sy <= '0; seg_ex <= '0; seg_ey <= '0;
            seg_za <= '0; seg_zb <= '0;
            o_errors <= 0;
        end else begin
            if (i_valid && o_ready) walk_segment(i_kind);
            // Compare each output transfer with the oldest expected pixel.
            if (o_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected output transfer");
                    o_errors <= o_errors + 1;
                end else begin
                    e = pixel_q.pop_front();
                    if (o_pixel_x !== e.px || o_pixel_y !== e.py || o_depth !== e.depth ||
                        o_in_bounds !== e.in_bounds || o_last_pixel !== e.last_pixel ||
                        o_no_pixel !== e.no_pixel) begin
                        o_errors <= o_errors + 1;
                        if (o_pixel_x !== e.px)
                            $error("pixel_x exp %0d got %0d", e.px, o_pixel_x);
                        if (o_pixel_y !== e.py)
                            $error("pixel_y exp %0d got %0d", e.py, o_pixel_y);
                        if (o_depth !== e.depth)
                            $error("depth exp %0d got %0d", e.depth, o_depth);
                        if (o_in_bounds !== e.in_bounds)
                            $error("in_bounds exp %0b got %0b", e.in_bounds, o_in_bounds);
                        if (o_last_pixel !== e.last_pixel)
                            $error("last_pixel exp %0b got %0b", e.last_pixel, o_last_pixel);
                        if (o_no_pixel !== e.no_pixel)
                            $error("no_pixel exp %0b got %0b", e.no_pixel, o_no_pixel);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    logic i_clk, i_rst_n, i_valid, o_ready, i_kind, o_valid, i_ready;
    logic [mldr_pkg::COORD_W-1:0] i_start_x, i_start_y, i_end_x, i_end_y;
    logic [mldr_pkg::ZW-1:0] i_start_inv_depth, i_end_inv_depth, o_depth;
    logic [mldr_pkg::CUR_W-2:0] o_pixel_x;
    logic [mldr_pkg::CUR_W-1:0] o_pixel_y;
    logic o_in_bounds, o_last_pixel, o_no_pixel;
    int errors, pending, cycles;
    int send_idle_pct, recv_idle_pct;
    int sent;

    midpoint_line_depth_rasterizer uut (.*);

    mldr_checker chk (.*, .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= recv_idle_pct);

    // One input transfer, with an optional random gap before it.
    task automatic push_item(input logic kind, input logic [13:0] sx, input logic [13:0] sy,
                             input logic [13:0] ex, input logic [13:0] ey,
                             input logic [15:0] za, input logic [15:0] zb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1; i_kind <= kind;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        i_start_inv_depth <= za; i_end_inv_depth <= zb;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic push_step();
        push_item(mldr_pkg::KIND_STEP, 14'($urandom), 14'($urandom), 14'($urandom),
                  14'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // A first-octant segment, short, with random subpixel ends and depths.
    task automatic push_segment();
        int sx, sy, len, rise, n;
        sx = $urandom_range(16383 - 400);
        sy = $urandom_range(16383 - 400);
        len = ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(60);
        rise = $urandom_range(len);
        push_item(mldr_pkg::KIND_LOAD, 14'(sx), 14'(sy), 14'(sx + len), 14'(sy + rise),
                  16'($urandom), 16'($urandom));
        n = len / 16 + $urandom_range(2);
        repeat (n) push_step();
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0; i_kind = mldr_pkg::KIND_LOAD;
        i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        i_start_inv_depth = '0; i_end_inv_depth = '0;
        send_idle_pct = 12; recv_idle_pct = 76; sent = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no-pixel after reset, extremes, zero length, off-octant.
        push_step();
        push_item(mldr_pkg::KIND_LOAD, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF,
                  16'hFFFF, 16'h0000);
        push_step();
        push_item(mldr_pkg::KIND_LOAD, 14'h0000, 14'h0000, 14'h0050, 14'h0030,
                  16'h0000, 16'hFFFF);
        repeat (7) push_step();
        push_item(mldr_pkg::KIND_LOAD, 14'h3F8F, 14'h3FF0, 14'h3FFF, 14'h3FFF,
                  16'hFFFF, 16'hFFFF);
        repeat (3) push_step();
        push_item(mldr_pkg::KIND_LOAD, 14'h0008, 14'h2000, 14'h0100, 14'h0000,
                  16'h1234, 16'hABCD);
        repeat (6) push_step();
        push_item(mldr_pkg::KIND_LOAD, 14'h0000, 14'h0000, 14'h0300, 14'h3FFF,
                  16'h8000, 16'h7FFF);
        repeat (4) push_step();

        // Random phases with changing idle mix.
        while (sent < 330) push_segment();
        send_idle_pct = 76; recv_idle_pct = 12;
        while (sent < 650) push_segment();
        send_idle_pct = 0; recv_idle_pct = 0;
        while (sent < 950) begin
            if ($urandom_range(19) == 0) push_step();
            else push_segment();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
